// ----- hw/rtl/sle_pkg.sv -----
package sle_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int MAX_SLOTS           = 5;
   localparam int SLOT_IDX_WIDTH      = $clog2(MAX_SLOTS);

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_TRUNC   = 2'd1;
   localparam logic [1:0] ERR_UNKNOWN = 2'd2;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_APOS      = 8'h27;
   localparam logic [7:0] CH_QUESTION  = 8'h3F;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_LC_A      = 8'h61;
   localparam logic [7:0] CH_LC_B      = 8'h62;
   localparam logic [7:0] CH_LC_F      = 8'h66;
   localparam logic [7:0] CH_LC_N      = 8'h6E;
   localparam logic [7:0] CH_LC_R      = 8'h72;
   localparam logic [7:0] CH_LC_T      = 8'h74;
   localparam logic [7:0] CH_LC_U      = 8'h75;
   localparam logic [7:0] CH_LC_V      = 8'h76;
   localparam logic [7:0] CH_LC_X      = 8'h78;
   localparam logic [7:0] CH_UC_A      = 8'h41;
   localparam logic [7:0] CH_UC_F      = 8'h46;
   localparam logic [7:0] CH_UC_U      = 8'h55;

   typedef enum logic [1:0] {
      PH_NORMAL = 2'd0,
      PH_ESCAPE = 2'd1,
      PH_DIGITS = 2'd2,
      PH_UTF8   = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] err;
   } slot_type;

   // one decoded input byte: up to MAX_SLOTS result transactions
   typedef struct packed {
      logic [SLOT_IDX_WIDTH-1:0]  nslots;
      logic                       end_mark;
      logic [15:0]                count;
      slot_type [MAX_SLOTS-1:0]   slot;
   } cmd_type;

endpackage

// ----- hw/rtl/sle_req_if.sv -----
interface sle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- hw/rtl/sle_rsp_if.sv -----
interface sle_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        kind;
   logic [15:0] char_count;
   logic [1:0]  error_code;
   logic        last;

   modport source (output valid, output out_byte, output kind, output char_count,
                   output error_code, output last, input ready);
   modport sink   (input valid, input out_byte, input kind, input char_count,
                   input error_code, input last, output ready);
endinterface

// ----- hw/rtl/sle_front.sv -----
module sle_front
   import sle_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       wide_mode,
   input  logic       in_valid,
   input  logic [7:0] in_byte,
   output logic       in_ready,
   output logic       cmd_valid,
   output cmd_type    cmd,
   input  logic       cmd_ready
);

   phase_type              phase_ff, phase_in;
   logic [3:0]             limit_ff, limit_in;
   logic [3:0]             seen_ff, seen_in;
   logic                   hex_ff, hex_in;
   logic [31:0]            accum_ff, accum_in;
   logic [1:0]             left_ff, left_in;
   logic                   multi_ff, multi_in;
   logic [COUNT_WIDTH-1:0] chars_ff, chars_in;

   logic                   accept;
   logic                   is_dec;
   logic                   nb_end, nb_esc, nb_lead;
   logic [1:0]             lead_left;
   logic [31:0]            lead_accum;
   logic                   esc_digit;
   logic [3:0]             eff_limit, eff_seen, seen_new;
   logic                   eff_hex, eff_multi;
   logic [31:0]            eff_accum, acc_new;
   logic [4:0]             dig_val;
   logic                   dig_ok;
   logic                   digit_go, run_normal;
   logic                   c1_v, c1_enc, c2_v, end_v;
   logic [31:0]            c1_code;
   logic [1:0]             c1_err;
   logic [7:0]             enc_byte [MAX_SLOTS];
   logic [SLOT_IDX_WIDTH-1:0] n1, n1_eff, c2_pos;
   logic [COUNT_WIDTH-1:0] cnt1, cnt2;
   logic [31:0]            cnt_ext;

   assign accept   = in_valid && in_ready;
   assign in_ready = cmd_ready;

   // classify the byte: decimal digit, closing quote, backslash or UTF-8 lead byte (wide mode)
   assign is_dec  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
   assign nb_end  = in_byte == CH_QUOTE;
   assign nb_esc  = in_byte == CH_BACKSLASH;
   assign nb_lead = wide_mode && in_byte[7];

   always_comb begin
      if (in_byte[7:5] == 3'b110) begin
         lead_left  = 2'd1;
         lead_accum = {27'd0, in_byte[4:0]};
      end else if (in_byte[7:4] == 4'b1110) begin
         lead_left  = 2'd2;
         lead_accum = {28'd0, in_byte[3:0]};
      end else begin
         lead_left  = 2'd3;
         lead_accum = {29'd0, in_byte[2:0]};
      end
   end

   // a decimal digit after a backslash opens an octal run on a fresh state
   assign esc_digit = (phase_ff == PH_ESCAPE) && is_dec;
   assign eff_limit = esc_digit ? 4'd3 : limit_ff;
   assign eff_seen  = esc_digit ? 4'd0 : seen_ff;
   assign eff_hex   = esc_digit ? 1'b0 : hex_ff;
   assign eff_multi = esc_digit ? 1'b0 : multi_ff;
   assign eff_accum = esc_digit ? 32'd0 : accum_ff;

   always_comb begin
      if (is_dec)
         dig_val = {1'b0, in_byte[3:0]};
      else if (eff_hex && in_byte >= CH_LC_A && in_byte <= CH_LC_F)
         dig_val = 5'(in_byte - CH_LC_A + 8'd10);
      else if (eff_hex && in_byte >= CH_UC_A && in_byte <= CH_UC_F)
         dig_val = 5'(in_byte - CH_UC_A + 8'd10);
      else
         dig_val = 5'd16;
   end

   assign dig_ok   = eff_hex ? (dig_val < 5'd16) : (dig_val < 5'd8);
   assign acc_new  = eff_hex ? {eff_accum[27:0], dig_val[3:0]}
                             : {eff_accum[28:0], dig_val[2:0]};
   assign seen_new = eff_seen + 4'd1;

   always_comb begin
      phase_in   = phase_ff;
      limit_in   = limit_ff;
      seen_in    = seen_ff;
      hex_in     = hex_ff;
      accum_in   = accum_ff;
      left_in    = left_ff;
      multi_in   = multi_ff;
      c1_v       = 1'b0;
      c1_code    = 32'd0;
      c1_enc     = wide_mode;
      c1_err     = ERR_NONE;
      c2_v       = 1'b0;
      end_v      = 1'b0;
      digit_go   = 1'b0;
      run_normal = 1'b0;

      unique case (phase_ff)
         PH_NORMAL: begin
            run_normal = 1'b1;
         end
         PH_ESCAPE: begin
            phase_in = PH_NORMAL;
            if (is_dec) begin
               digit_go = 1'b1;
            end else begin
               unique case (in_byte)
                  CH_LC_A: begin c1_v = 1'b1; c1_code = 32'd7;  end
                  CH_LC_B: begin c1_v = 1'b1; c1_code = 32'd8;  end
                  CH_LC_F: begin c1_v = 1'b1; c1_code = 32'd12; end
                  CH_LC_N: begin c1_v = 1'b1; c1_code = 32'd10; end
                  CH_LC_R: begin c1_v = 1'b1; c1_code = 32'd13; end
                  CH_LC_T: begin c1_v = 1'b1; c1_code = 32'd9;  end
                  CH_LC_V: begin c1_v = 1'b1; c1_code = 32'd11; end
                  CH_LC_U: begin
                     phase_in = PH_DIGITS; limit_in = 4'd4; seen_in = 4'd0;
                     hex_in = 1'b1; multi_in = 1'b1; accum_in = 32'd0;
                  end
                  CH_UC_U: begin
                     phase_in = PH_DIGITS; limit_in = 4'd8; seen_in = 4'd0;
                     hex_in = 1'b1; multi_in = 1'b1; accum_in = 32'd0;
                  end
                  CH_LC_X: begin
                     phase_in = PH_DIGITS; limit_in = 4'd2; seen_in = 4'd0;
                     hex_in = 1'b1; multi_in = 1'b0; accum_in = 32'd0;
                  end
                  CH_APOS, CH_QUOTE, CH_QUESTION, CH_BACKSLASH: begin
                     c1_v    = 1'b1;
                     c1_code = {24'd0, in_byte};
                  end
                  default: begin
                     c1_v    = 1'b1;
                     c1_code = {24'd0, in_byte};
                     c1_err  = ERR_UNKNOWN;
                  end
               endcase
            end
         end
         PH_DIGITS: begin
            digit_go = 1'b1;
         end
         PH_UTF8: begin
            c1_enc = 1'b1;
            if (in_byte[7:6] != 2'b10) begin
               phase_in = PH_NORMAL;
               c1_v     = 1'b1;
               end_v    = nb_end;
            end else begin
               accum_in = {11'd0, accum_ff[14:0], in_byte[5:0]};
               left_in  = left_ff - 2'd1;
               if (left_ff == 2'd1) begin
                  phase_in = PH_NORMAL;
                  c1_v     = 1'b1;
                  c1_code  = {11'd0, accum_ff[14:0], in_byte[5:0]};
               end
            end
         end
         default: begin
            run_normal = 1'b1;
         end
      endcase

      if (digit_go) begin
         limit_in = eff_limit;
         hex_in   = eff_hex;
         multi_in = eff_multi;
         c1_enc   = wide_mode || eff_multi;
         if (dig_ok) begin
            accum_in = acc_new;
            seen_in  = seen_new;
            phase_in = PH_DIGITS;
            if (seen_new >= eff_limit) begin
               phase_in = PH_NORMAL;
               c1_v     = 1'b1;
               c1_code  = acc_new;
            end
         end else begin
            accum_in   = eff_accum;
            seen_in    = eff_seen;
            c1_v       = 1'b1;
            c1_code    = eff_accum;
            c1_err     = ERR_TRUNC;
            run_normal = 1'b1;
         end
      end

      if (run_normal) begin
         phase_in = PH_NORMAL;
         if (nb_end) begin
            end_v = 1'b1;
         end else if (nb_esc) begin
            phase_in = PH_ESCAPE;
         end else if (nb_lead) begin
            multi_in = 1'b1;
            left_in  = lead_left;
            accum_in = lead_accum;
            phase_in = PH_UTF8;
         end else begin
            c2_v = 1'b1;
         end
      end
   end

   // encode the escaped or decoded character
   always_comb begin
      for (int i = 0; i < MAX_SLOTS; i++)
         enc_byte[i] = 8'd0;
      if (!c1_enc || c1_code < 32'h80) begin
         n1          = SLOT_IDX_WIDTH'(1);
         enc_byte[0] = c1_code[7:0];
      end else if (c1_code < 32'h800) begin
         n1          = SLOT_IDX_WIDTH'(2);
         enc_byte[0] = 8'hC0 | c1_code[13:6];
         enc_byte[1] = {2'b10, c1_code[5:0]};
      end else if (c1_code < 32'h10000) begin
         n1          = SLOT_IDX_WIDTH'(3);
         enc_byte[0] = 8'hE0 | c1_code[19:12];
         enc_byte[1] = {2'b10, c1_code[11:6]};
         enc_byte[2] = {2'b10, c1_code[5:0]};
      end else begin
         n1          = SLOT_IDX_WIDTH'(4);
         enc_byte[0] = 8'hF0 | c1_code[25:18];
         enc_byte[1] = {2'b10, c1_code[17:12]};
         enc_byte[2] = {2'b10, c1_code[11:6]};
         enc_byte[3] = {2'b10, c1_code[5:0]};
      end
   end

   assign n1_eff = c1_v ? n1 : '0;
   assign c2_pos = n1_eff;

   // saturating character count, end marker reports the count after this byte
   assign cnt1    = (c1_v && !(&chars_ff)) ? chars_ff + 1'b1 : chars_ff;
   assign cnt2    = (c2_v && !(&cnt1)) ? cnt1 + 1'b1 : cnt1;
   assign chars_in = end_v ? '0 : cnt2;
   assign cnt_ext = 32'(cnt2);

   always_comb begin
      cmd.nslots   = n1_eff + SLOT_IDX_WIDTH'(c2_v) + SLOT_IDX_WIDTH'(end_v);
      cmd.end_mark = end_v;
      cmd.count    = cnt_ext[15:0];
      for (int i = 0; i < MAX_SLOTS; i++) begin
         if (SLOT_IDX_WIDTH'(i) < n1_eff) begin
            cmd.slot[i].data = enc_byte[i];
            cmd.slot[i].err  = c1_err;
         end else if (c2_v && SLOT_IDX_WIDTH'(i) == c2_pos) begin
            cmd.slot[i].data = in_byte;
            cmd.slot[i].err  = ERR_NONE;
         end else begin
            cmd.slot[i].data = 8'd0;
            cmd.slot[i].err  = ERR_NONE;
         end
      end
   end

   assign cmd_valid = in_valid && (cmd.nslots != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NORMAL;
         limit_ff <= 4'd0;
         seen_ff  <= 4'd0;
         hex_ff   <= 1'b0;
         accum_ff <= 32'd0;
         left_ff  <= 2'd0;
         multi_ff <= 1'b0;
         chars_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         limit_ff <= limit_in;
         seen_ff  <= seen_in;
         hex_ff   <= hex_in;
         accum_ff <= accum_in;
         left_ff  <= left_in;
         multi_ff <= multi_in;
         chars_ff <= chars_in;
      end
   end

endmodule

// ----- hw/rtl/sle_queue.sv -----
module sle_queue
   import sle_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_data,
   output logic    push_ready,
   output logic    pop_valid,
   output cmd_type pop_data,
   input  logic    pop_ready
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   cmd_type                store_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   fill_ff, fill_in;
   logic                   do_push, do_pop;

   assign push_ready = fill_ff != CNT_WIDTH'(DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         fill_in = fill_ff + 1'b1;
      else if (do_pop && !do_push)
         fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push)
         store_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ----- hw/rtl/sle_back.sv -----
module sle_back
   import sle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_ready,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [7:0]  out_byte,
   output logic        out_kind,
   output logic [15:0] out_count,
   output logic [1:0]  out_err,
   output logic        out_last
);

   cmd_type                   cur_ff;
   logic                      cur_valid_ff;
   logic [SLOT_IDX_WIDTH-1:0] idx_ff;
   logic                      fire, is_last;

   assign fire      = cur_valid_ff && out_ready;
   assign is_last   = idx_ff == (cur_ff.nslots - 1'b1);
   assign cmd_ready = !cur_valid_ff || (fire && is_last);

   assign out_valid = cur_valid_ff;
   assign out_kind  = cur_ff.end_mark && is_last;
   assign out_byte  = out_kind ? 8'd0 : cur_ff.slot[idx_ff].data;
   assign out_count = out_kind ? cur_ff.count : 16'd0;
   assign out_err   = out_kind ? ERR_NONE : cur_ff.slot[idx_ff].err;
   assign out_last  = is_last;

   always_ff @(posedge clock) begin
      if (cmd_valid && cmd_ready)
         cur_ff <= cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (cmd_valid && cmd_ready) begin
         cur_valid_ff <= 1'b1;
         idx_ff       <= '0;
      end else if (fire && is_last) begin
         cur_valid_ff <= 1'b0;
      end else if (fire) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (idx_ff < cur_ff.nslots))
      else $error("slot index beyond transaction count");

   a_no_empty_cmd: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (cur_ff.nslots != '0))
      else $error("empty command reached the sequencer");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (fire && !is_last) |=> (cur_valid_ff && idx_ff == $past(idx_ff) + 1'b1))
      else $error("sequencer failed to advance");

endmodule

// ----- hw/rtl/string_literal_unescaper.sv -----
// Channel   Direction  Payload                                          Handshake
// req_chan  in         in_byte[7:0]                                     valid/ready
// rsp_chan  out        out_byte, kind, char_count, error_code, last     valid/ready
// csr       in         csr_wr_data = wide_mode                          csr_wr_en
//
// One source byte is taken per cycle while the command queue has room. Each byte
// gives 0 to 5 result transactions, sent by the back sequencer one per cycle while
// rsp_chan is ready, so the output side sets the rate; a multi-byte character holds
// the input only after the queue fills. Results are registered in the queue and in sle_back.
// Reset is synchronous and clears decoder state, queue pointers and wide_mode.
// A stalled rsp_chan holds the current result and lets the queue absorb bytes.
module string_literal_unescaper
   import sle_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic csr_wr_data,
   sle_req_if.sink   req_chan,
   sle_rsp_if.source rsp_chan
);

   logic    wide_ff;
   logic    fq_valid, fq_ready;
   cmd_type fq_cmd;
   logic    qb_valid, qb_ready;
   cmd_type qb_cmd;

   // hold wide_mode; the user must write it only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset)
         wide_ff <= 1'b0;
      else if (csr_wr_en)
         wide_ff <= csr_wr_data;
   end

   // front: decode escapes and UTF-8, build one command per source byte that yields results
   sle_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .wide_mode (wide_ff),
      .in_valid  (req_chan.valid),
      .in_byte   (req_chan.in_byte),
      .in_ready  (req_chan.ready),
      .cmd_valid (fq_valid),
      .cmd       (fq_cmd),
      .cmd_ready (fq_ready)
   );

   // decouple decode from result delivery
   sle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_data  (fq_cmd),
      .push_ready (fq_ready),
      .pop_valid  (qb_valid),
      .pop_data   (qb_cmd),
      .pop_ready  (qb_ready)
   );

   // back: advance through the command's slots, one transaction per cycle while rsp_chan is ready
   sle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (qb_valid),
      .cmd       (qb_cmd),
      .cmd_ready (qb_ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_byte  (rsp_chan.out_byte),
      .out_kind  (rsp_chan.kind),
      .out_count (rsp_chan.char_count),
      .out_err   (rsp_chan.error_code),
      .out_last  (rsp_chan.last)
   );

endmodule
